// File: design/kwm_pkg.sv
// Shared constants and types for the k-way sorted run merge block.
package kwm_pkg;
   localparam int DefMaxRows = 16;
   localparam int DefMaxCols = 256;
   localparam int DefDataWidth = 32;
   localparam int RowCountW = 5;
   localparam int RowLengthW = 9;
   localparam int CsrAddrW = 1;
   localparam int CsrDataW = 9;
   localparam logic [CsrAddrW-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CsrAddrW-1:0] CSR_ROW_LENGTH = 1'b1;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Control from the sequencer to the merge datapath.
   typedef struct packed {
      logic start;      // begin a new merge pass
      logic step;       // advance one merge step
   } merge_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } merge_sts_type;
endpackage

// File: design/kwm_merge.sv
// Bottom-up merge engine: one key comparator shared across all merge steps.
module kwm_merge #(
   parameter int MAX_ROWS = kwm_pkg::DefMaxRows,
   parameter int MAX_COLS = kwm_pkg::DefMaxCols,
   parameter int DATA_WIDTH = kwm_pkg::DefDataWidth,
   localparam int Depth = MAX_ROWS * MAX_COLS,
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int CW = $clog2(Depth + 1),
   localparam int RW = $clog2(MAX_ROWS + 1),
   localparam int LW = $clog2(MAX_COLS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RW-1:0]         rows,
   input  logic [LW-1:0]         cols,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data,
   output kwm_pkg::merge_sts_type sts
);
   import kwm_pkg::*;

   // Phases of the merge sequencer.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAIR  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_COPYR = 3'd4;
   localparam logic [2:0] S_COPYW = 3'd5;

   // The recursive halving is reproduced bottom up: a schedule of (lo, n)
   // nodes in post order is kept in a small stack of frames. Each level of
   // halving keeps the opened node plus its pending sibling on the stack.
   localparam int SD = 2 * RW + 1;
   localparam int SPW = $clog2(SD + 1);

   logic [DATA_WIDTH-1:0] elem_mem [Depth];
   logic [DATA_WIDTH-1:0] scr_mem  [Depth];

   logic [2:0]     state_ff, state_in;
   logic [RW-1:0]  stk_lo_ff [SD];
   logic [RW-1:0]  stk_n_ff  [SD];
   logic           stk_ph_ff [SD];
   logic [SPW-1:0] sp_ff;
   logic [CW-1:0]  a_ff, a_end_ff, b_ff, b_end_ff, k_ff, base_ff;
   logic [DATA_WIDTH-1:0] da_ff, elem_q_ff;
   logic [LW-1:0]  len_ff;

   logic [RW-1:0] top_lo, top_n, up;
   logic          top_ph;
   assign top_lo = stk_lo_ff[sp_ff[SPW-1:0] - 1'b1];
   assign top_n  = stk_n_ff[sp_ff - 1'b1];
   assign top_ph = stk_ph_ff[sp_ff - 1'b1];
   assign up = RW'((top_n + 1'b1) >> 1);

   // Shared comparator on order-preserving keys; the b head is the fresh read.
   logic a_lt_b, a_live, b_live;
   assign a_lt_b = (da_ff ^ {1'b1, {(DATA_WIDTH-1){1'b0}}}) <
                   (elem_q_ff ^ {1'b1, {(DATA_WIDTH-1){1'b0}}});
   assign a_live = a_ff < a_end_ff;
   assign b_live = b_ff < b_end_ff;

   // Node bounds, one multiplier per bound, used each time a node is opened.
   logic [CW-1:0] n_base, n_mid, n_end;
   assign n_base = CW'(top_lo * len_ff);
   assign n_mid  = CW'((top_lo + up) * len_ff);
   assign n_end  = CW'((top_lo + top_n) * len_ff);

   // External access to element store shares ports when idle.
   logic el_we;
   logic [AW-1:0] el_wa, el_ra;
   logic [DATA_WIDTH-1:0] el_wd;
   logic sc_we;
   logic [AW-1:0] sc_wa, sc_ra;
   logic [DATA_WIDTH-1:0] sc_wd, sc_q_ff;

   always_comb begin
      el_we = 1'b0; el_wa = wr_addr; el_wd = wr_data; el_ra = rd_addr;
      sc_we = 1'b0; sc_wa = k_ff[AW-1:0]; sc_wd = da_ff; sc_ra = k_ff[AW-1:0];
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            el_we = wr_en;
            if (start) state_in = S_PAIR;
         end
         S_PAIR: begin
            if (sp_ff == '0) state_in = S_IDLE;
            else if (top_n > 1 && top_ph) begin
               el_ra = n_base[AW-1:0];
               state_in = S_RD;
            end
         end
         S_RD: begin
            el_ra = b_ff[AW-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!a_live && !b_live) state_in = S_COPYR;
            else begin
               sc_we = 1'b1;
               // next a head: advanced when a wins, reread otherwise
               if (a_live && (!b_live || a_lt_b)) begin
                  sc_wd = da_ff; el_ra = AW'(a_ff + 1'b1);
               end else begin
                  sc_wd = elem_q_ff; el_ra = a_ff[AW-1:0];
               end
               state_in = S_RD;
            end
         end
         S_COPYR: state_in = (k_ff < b_end_ff) ? S_COPYW : S_PAIR;
         S_COPYW: begin
            el_we = 1'b1; el_wa = AW'(k_ff - 1'b1); el_wd = sc_q_ff;
            state_in = S_COPYR;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (el_we) elem_mem[el_wa] <= el_wd;
      elem_q_ff <= elem_mem[el_ra];
      if (sc_we) scr_mem[sc_wa] <= sc_wd;
      sc_q_ff <= scr_mem[sc_ra];
   end
   assign rd_data = elem_q_ff;

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: if (start) begin
               stk_lo_ff[0] <= '0; stk_n_ff[0] <= rows; stk_ph_ff[0] <= 1'b0;
               sp_ff <= SPW'(1);
               len_ff <= cols;
            end
            S_PAIR: if (sp_ff != '0) begin
               if (top_n <= 1) sp_ff <= sp_ff - 1'b1;
               else if (!top_ph) begin
                  // open node: push upper child below lower child
                  stk_ph_ff[sp_ff - 1'b1] <= 1'b1;
                  stk_lo_ff[sp_ff] <= RW'(top_lo + up);
                  stk_n_ff[sp_ff] <= RW'(top_n - up);
                  stk_ph_ff[sp_ff] <= 1'b0;
                  stk_lo_ff[sp_ff + 1'b1] <= top_lo;
                  stk_n_ff[sp_ff + 1'b1] <= up;
                  stk_ph_ff[sp_ff + 1'b1] <= 1'b0;
                  sp_ff <= SPW'(sp_ff + 2'd2);
               end else begin
                  a_ff <= n_base; a_end_ff <= n_mid;
                  b_ff <= n_mid;  b_end_ff <= n_end;
                  k_ff <= n_base; base_ff <= n_base;
                  sp_ff <= sp_ff - 1'b1;
               end
            end
            S_RD: da_ff <= elem_q_ff;
            S_CMP: begin
               if (a_live || b_live) begin
                  k_ff <= k_ff + 1'b1;
                  if (a_live && (!b_live || a_lt_b)) a_ff <= a_ff + 1'b1;
                  else b_ff <= b_ff + 1'b1;
               end else k_ff <= base_ff;
            end
            S_COPYR: k_ff <= k_ff + 1'b1;
            default: ;
         endcase
      end
   end

   assign sts.busy = (state_ff != S_IDLE) || start;
   assign sts.done = (state_ff == S_PAIR) && (sp_ff == '0);

   logic unused_rd;
   assign unused_rd = rd_en;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(SD)) else $error("merge stack overflow");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (k_ff <= b_end_ff)) else $error("merge write past node");
   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> (state_ff == S_IDLE)) else $error("merge did not finish");
endmodule

// File: design/k_way_sorted_run_merge.sv
// Top level of the k-way sorted run merge block.
// Loads (op 0) are accepted while idle and store elements row by row. The
// first fetch after a complete set runs the merge in place: a shared
// comparator walks each two-way merge of the recursive halving, writing each
// element to scratch and then copying it back. A fetch result passes through
// T_READ and T_DATA (after T_MERGE for the first fetch), set by the registered
// memory read, and is shown in T_OUT; the next beat is taken once the result
// leaves, so a new fetch is not accepted while one is still in flight.
module k_way_sorted_run_merge #(
   parameter int MAX_ROWS = kwm_pkg::DefMaxRows,
   parameter int MAX_COLS = kwm_pkg::DefMaxCols,
   parameter int DATA_WIDTH = kwm_pkg::DefDataWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [kwm_pkg::CsrAddrW-1:0]    csr_index,
   input  logic [kwm_pkg::CsrDataW-1:0]    csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic signed [DATA_WIDTH-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [DATA_WIDTH-1:0]    rsp_merged_value,
   output logic                            rsp_final_flag,
   output logic                            rsp_empty_flag
);
   import kwm_pkg::*;

   localparam int Depth = MAX_ROWS * MAX_COLS;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int LW = $clog2(MAX_COLS + 1);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_MERGE = 3'd1;
   localparam logic [2:0] T_READ  = 3'd2;
   localparam logic [2:0] T_DATA  = 3'd3;
   localparam logic [2:0] T_OUT   = 3'd4;

   logic [RowCountW-1:0]  row_count_ff;
   logic [RowLengthW-1:0] row_length_ff;
   logic [2:0]  state_ff;
   logic [CW-1:0] loaded_ff, fetch_ff, mlen_ff;
   logic        done_ff, final_ff, empty_ff;
   logic [DATA_WIDTH-1:0] data_ff;

   // Effective register values with clamping.
   logic [RW-1:0] rows;
   logic [LW-1:0] cols;
   logic [CW-1:0] total;
   always_comb begin
      if (row_count_ff == '0) rows = RW'(1);
      else if (32'(row_count_ff) > MAX_ROWS) rows = RW'(MAX_ROWS);
      else rows = RW'(row_count_ff);
      if (row_length_ff == '0) cols = LW'(1);
      else if (32'(row_length_ff) > MAX_COLS) cols = LW'(MAX_COLS);
      else cols = LW'(row_length_ff);
   end
   assign total = CW'(rows * cols);

   logic acc, is_load;
   assign req_stall = (state_ff != T_IDLE);
   assign acc = req_valid && !req_stall;
   assign is_load = (req_op == OP_LOAD);

   logic wr_en, start;
   logic [AW-1:0] wr_addr;
   logic [CW-1:0] ld_base;
   assign ld_base = done_ff ? '0 : loaded_ff;
   assign wr_en = acc && is_load && (ld_base < total);
   assign wr_addr = ld_base[AW-1:0];
   assign start = acc && !is_load && !done_ff && (loaded_ff >= total);

   logic [DATA_WIDTH-1:0] rd_data;
   merge_sts_type msts;

   kwm_merge #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .DATA_WIDTH(DATA_WIDTH))
   u_merge (
      .clock(clock), .reset(reset), .start(start), .rows(rows), .cols(cols),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_value),
      .rd_en(state_ff == T_READ), .rd_addr(fetch_ff[AW-1:0]),
      .rd_data(rd_data), .sts(msts)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RowCountW'(1);
         row_length_ff <= RowLengthW'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_COUNT:  row_count_ff <= csr_data[RowCountW-1:0];
            CSR_ROW_LENGTH: row_length_ff <= csr_data[RowLengthW-1:0];
            default: ;
         endcase
      end
   end

   // Fetch sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         loaded_ff <= '0; fetch_ff <= '0; mlen_ff <= '0; done_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            T_IDLE: if (acc) begin
               if (is_load) begin
                  done_ff <= 1'b0;
                  fetch_ff <= '0;
                  loaded_ff <= (ld_base < total) ? ld_base + 1'b1 : ld_base;
               end else if (start) begin
                  state_ff <= T_MERGE;
                  mlen_ff <= total; fetch_ff <= '0;
               end else if (done_ff && fetch_ff < mlen_ff) state_ff <= T_READ;
               else begin
                  data_ff <= '0; final_ff <= 1'b0; empty_ff <= 1'b1;
                  state_ff <= T_OUT;
               end
            end
            T_MERGE: if (msts.done) begin
               done_ff <= 1'b1;
               state_ff <= T_READ;
            end
            T_READ: state_ff <= T_DATA;
            T_DATA: begin
               data_ff <= rd_data;
               final_ff <= (fetch_ff + 1'b1 == mlen_ff);
               empty_ff <= 1'b0;
               fetch_ff <= fetch_ff + 1'b1;
               state_ff <= T_OUT;
            end
            T_OUT: if (!rsp_stall) state_ff <= T_IDLE;
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_valid = (state_ff == T_OUT);
   assign rsp_merged_value = data_ff;
   assign rsp_final_flag = final_ff;
   assign rsp_empty_flag = empty_ff;

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_final_flag && rsp_empty_flag)) else $error("flags clash");
   a_fetch_bound: assert property (@(posedge clock) disable iff (reset)
      fetch_ff <= mlen_ff || !done_ff) else $error("fetch past end");
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CW'(Depth)) else $error("load count overflow");
endmodule
